[rtl/tup_pkg.sv]
// Shared types, constants and fixed-point helpers for the texture UV placement block.
package tup_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CW = 32;
	localparam int QW = CW + 1;
	localparam int NW = CW + FRAC_BITS;
	localparam int WW = 66;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [WW-1:0] wide_t;

	localparam coord_t FX_ONE  = 32'sd1 <<< FRAC_BITS;
	localparam coord_t FX_HALF = 32'sd1 <<< (FRAC_BITS - 1);
	localparam coord_t SAT_MAX = 32'sh7FFF_FFFF;
	localparam coord_t SAT_MIN = 32'sh8000_0000;
	localparam coord_t SYM_MIN = 32'sh8000_0001;

	localparam logic [QW-1:0] Q_NEG_LIM = QW'(1) << (CW - 1);
	localparam logic [QW-1:0] Q_POS_LIM = Q_NEG_LIM - QW'(1);

	typedef enum logic [2:0] {
		REG_COVERAGE,
		REG_FRAME_SHIFT,
		REG_FRAME_TURN,
		REG_REPEAT,
		REG_OFFSET,
		REG_UV_TURN,
		REG_MODE
	} cfg_reg_t;

	typedef struct packed {
		logic stagger;
		logic wrap_v;
		logic wrap_u;
		logic mirror_v;
		logic mirror_u;
	} mode_t;

	typedef struct packed {
		logic [NW-1:0] num;
		logic [CW-1:0] den;
		logic          neg;
		logic          zero;
		logic          ovf;
	} div_in_t;

	typedef struct packed {
		logic [QW-1:0] quo;
		logic          neg;
		logic          zero;
		logic          ovf;
	} div_out_t;

	function automatic coord_t sat32(input wide_t x);
		if (x > wide_t'(SAT_MAX)) return SAT_MAX;
		if (x < wide_t'(SAT_MIN)) return SAT_MIN;
		return x[CW-1:0];
	endfunction

	function automatic coord_t satsym(input wide_t x);
		if (x > wide_t'(SAT_MAX)) return SAT_MAX;
		if (x < wide_t'(SYM_MIN)) return SYM_MIN;
		return x[CW-1:0];
	endfunction

	// add half an LSB, then floor shift
	function automatic wide_t round_prod(input wide_t p);
		return (p + wide_t'(FX_HALF)) >>> FRAC_BITS;
	endfunction

	function automatic coord_t mirror(input coord_t x);
		wide_t f;
		f = wide_t'(x[FRAC_BITS-1:0]);
		return sat32(wide_t'(x) - f + wide_t'(FX_ONE) - f);
	endfunction

endpackage

[rtl/tup_turn.sv]
// Two-stage rotation of a coordinate pair about (0.5,0.5).
module tup_turn (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_vld,
	input  logic                in_tag,
	input  tup_pkg::coord_t     in_u,
	input  tup_pkg::coord_t     in_v,
	input  logic [63:0]         turn,
	output logic                out_vld,
	output logic                out_tag,
	output tup_pkg::coord_t     out_u,
	output tup_pkg::coord_t     out_v
);

	tup_pkg::coord_t c, s, x, y;
	logic signed [63:0] cx_s1, sy_s1, cy_s1, sx_s1;
	tup_pkg::coord_t u_s1, v_s1, u_s2, v_s2;
	logic id_s1, tag_s1, tag_s2, vld_s1, vld_s2;
	tup_pkg::wide_t nu, nv;

	assign c = turn[31:0];
	assign s = turn[63:32];
	assign x = tup_pkg::satsym(tup_pkg::wide_t'(in_u) - tup_pkg::wide_t'(tup_pkg::FX_HALF));
	assign y = tup_pkg::satsym(tup_pkg::wide_t'(in_v) - tup_pkg::wide_t'(tup_pkg::FX_HALF));

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s1  <= c * x;
			sy_s1  <= s * y;
			cy_s1  <= c * y;
			sx_s1  <= s * x;
			id_s1  <= (c == tup_pkg::FX_ONE) && (s == '0);
			u_s1   <= in_u;
			v_s1   <= in_v;
			tag_s1 <= in_tag;
		end
	end

	assign nu = tup_pkg::round_prod(tup_pkg::wide_t'(cx_s1) - tup_pkg::wide_t'(sy_s1))
		+ tup_pkg::wide_t'(tup_pkg::FX_HALF);
	assign nv = tup_pkg::round_prod(tup_pkg::wide_t'(cy_s1) + tup_pkg::wide_t'(sx_s1))
		+ tup_pkg::wide_t'(tup_pkg::FX_HALF);

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s2   <= id_s1 ? u_s1 : tup_pkg::sat32(nu);
			v_s2   <= id_s1 ? v_s1 : tup_pkg::sat32(nv);
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	assign out_vld = vld_s2;
	assign out_tag = tag_s2;
	assign out_u   = u_s2;
	assign out_v   = v_s2;

endmodule

[rtl/tup_div.sv]
// Pipelined restoring divider, two lanes, one quotient bit per stage.
module tup_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_vld,
	input  logic                        in_tag,
	input  tup_pkg::div_in_t  [1:0]     din,
	output logic                        out_vld,
	output logic                        out_tag,
	output tup_pkg::div_out_t [1:0]     dout
);

	localparam int CW = tup_pkg::CW;
	localparam int QW = tup_pkg::QW;
	localparam int NW = tup_pkg::NW;
	localparam int BW = $clog2(NW);

	typedef struct packed {
		logic [NW-1:0] num;
		logic [CW-1:0] den;
		logic [CW-1:0] rem;
		logic [QW-1:0] quo;
		logic          neg;
		logic          zero;
		logic          ovf;
	} dstage_t;

	dstage_t [1:0] st_s [0:QW];
	logic vld_s [0:QW];
	logic tag_s [0:QW];
	dstage_t [1:0] init;

	function automatic dstage_t div_step(input dstage_t p, input logic [BW-1:0] b);
		dstage_t r;
		logic [CW:0] trial;
		r = p;
		trial = {p.rem, p.num[b]};
		if (trial >= {1'b0, p.den}) begin
			r.rem = CW'(trial - {1'b0, p.den});
			r.quo[b] = 1'b1;
		end else begin
			r.rem = trial[CW-1:0];
		end
		return r;
	endfunction

	// bits above the quotient range seed the remainder
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			init[l].num  = din[l].num;
			init[l].den  = din[l].den;
			init[l].rem  = CW'(din[l].num >> QW);
			init[l].quo  = '0;
			init[l].neg  = din[l].neg;
			init[l].zero = din[l].zero;
			init[l].ovf  = din[l].ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[0]  <= init;
			tag_s[0] <= in_tag;
			for (int k = 1; k <= QW; k++) begin
				tag_s[k] <= tag_s[k-1];
				for (int l = 0; l < 2; l++) begin
					st_s[k][l] <= div_step(st_s[k-1][l], BW'(QW - k));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QW; k++) vld_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_vld;
			for (int k = 1; k <= QW; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			dout[l].quo  = st_s[QW][l].quo;
			dout[l].neg  = st_s[QW][l].neg;
			dout[l].zero = st_s[QW][l].zero;
			dout[l].ovf  = st_s[QW][l].ovf;
		end
	end

	assign out_vld = vld_s[QW];
	assign out_tag = tag_s[QW];

	a_rem_u: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[QW] && !st_s[QW][0].ovf && !st_s[QW][0].zero
		|-> st_s[QW][0].rem < st_s[QW][0].den)
		else $error("u lane remainder not below divisor");

	a_rem_v: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[QW] && !st_s[QW][1].ovf && !st_s[QW][1].zero
		|-> st_s[QW][1].rem < st_s[QW][1].den)
		else $error("v lane remainder not below divisor");

endmodule

[rtl/tup_tile.sv]
// Repeat scaling, offset, stagger and mirroring in three stages.
module tup_tile (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_vld,
	input  logic                in_tag,
	input  tup_pkg::coord_t     in_u,
	input  tup_pkg::coord_t     in_v,
	input  logic [63:0]         rep,
	input  logic [63:0]         off,
	input  tup_pkg::mode_t      mode,
	output logic                out_vld,
	output logic                out_tag,
	output tup_pkg::coord_t     out_u,
	output tup_pkg::coord_t     out_v
);

	tup_pkg::coord_t rep_u, rep_v, off_u, off_v;
	logic signed [63:0] pu_s1, pv_s1;
	tup_pkg::coord_t su, sv, u_s2, v_s2, u_s3, v_s3, u_st, v_mr;
	logic tag_s1, tag_s2, tag_s3, vld_s1, vld_s2, vld_s3;

	assign rep_u = rep[31:0];
	assign rep_v = rep[63:32];
	assign off_u = off[31:0];
	assign off_v = off[63:32];

	always_ff @(posedge clk) begin
		if (adv) begin
			pu_s1  <= in_u * rep_u;
			pv_s1  <= in_v * rep_v;
			tag_s1 <= in_tag;
		end
	end

	assign su = tup_pkg::sat32(tup_pkg::round_prod(tup_pkg::wide_t'(pu_s1)));
	assign sv = tup_pkg::sat32(tup_pkg::round_prod(tup_pkg::wide_t'(pv_s1)));

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s2   <= tup_pkg::sat32(tup_pkg::wide_t'(su) + tup_pkg::wide_t'(off_u));
			v_s2   <= tup_pkg::sat32(tup_pkg::wide_t'(sv) + tup_pkg::wide_t'(off_v));
			tag_s2 <= tag_s1;
		end
	end

	// odd rows shift u by half when staggered and may flip v; odd columns may flip u
	always_comb begin
		u_st = u_s2;
		v_mr = v_s2;
		if (v_s2[tup_pkg::FRAC_BITS]) begin
			if (mode.stagger)
				u_st = tup_pkg::sat32(tup_pkg::wide_t'(u_s2) + tup_pkg::wide_t'(tup_pkg::FX_HALF));
			if (mode.mirror_v)
				v_mr = tup_pkg::mirror(v_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s3   <= (mode.mirror_u && u_st[tup_pkg::FRAC_BITS]) ? tup_pkg::mirror(u_st) : u_st;
			v_s3   <= v_mr;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign out_vld = vld_s3;
	assign out_tag = tag_s3;
	assign out_u   = u_s3;
	assign out_v   = v_s3;

endmodule

[rtl/texture_uv_placement.sv]
// Top level of the texture UV placement pipeline.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  input   | in        | in_valid / in_ready   | u_in, v_in
//  output  | out       | out_valid / out_ready | u_out, v_out, in_frame
//  config  | in        | cfg_wen               | cfg_index, cfg_data
//
// One coordinate pair enters per cycle unless the pipe holds. The stages are frame
// rotation (2), frame shift (1), coverage divider (34, one quotient bit per stage
// after the first), quotient saturation (1), tiling (3), UV rotation (2) and the
// output register. Reset clears all valid bits and loads the register defaults.
// The whole pipe holds together while the output register is full and not taken;
// a bubble at the output always lets a new transfer in.
module texture_uv_placement (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tup_pkg::coord_t     u_in,
	input  tup_pkg::coord_t     v_in,
	output logic                out_valid,
	input  logic                out_ready,
	output tup_pkg::coord_t     u_out,
	output tup_pkg::coord_t     v_out,
	output logic                in_frame,
	input  logic                cfg_wen,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data
);

	localparam int CW = tup_pkg::CW;
	localparam int QW = tup_pkg::QW;
	localparam int FB = tup_pkg::FRAC_BITS;

	// configuration registers
	logic [63:0] cov_q, shift_q, fturn_q, rep_q, off_q, uvturn_q;
	tup_pkg::mode_t mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cov_q    <= {tup_pkg::FX_ONE, tup_pkg::FX_ONE};
			shift_q  <= '0;
			fturn_q  <= {32'sd0, tup_pkg::FX_ONE};
			rep_q    <= {tup_pkg::FX_ONE, tup_pkg::FX_ONE};
			off_q    <= '0;
			uvturn_q <= {32'sd0, tup_pkg::FX_ONE};
			mode_q   <= tup_pkg::mode_t'(5'b01100);
		end else if (cfg_wen) begin
			case (tup_pkg::cfg_reg_t'(cfg_index))
				tup_pkg::REG_COVERAGE:    cov_q    <= cfg_data;
				tup_pkg::REG_FRAME_SHIFT: shift_q  <= cfg_data;
				tup_pkg::REG_FRAME_TURN:  fturn_q  <= cfg_data;
				tup_pkg::REG_REPEAT:      rep_q    <= cfg_data;
				tup_pkg::REG_OFFSET:      off_q    <= cfg_data;
				tup_pkg::REG_UV_TURN:     uvturn_q <= cfg_data;
				tup_pkg::REG_MODE:        mode_q   <= tup_pkg::mode_t'(cfg_data[4:0]);
				default: ;
			endcase
		end
	end

	// global advance: move everything unless a finished result sits untaken
	logic adv;
	logic out_vld_q, frame_q;
	tup_pkg::coord_t u_out_q, v_out_q;

	assign adv      = !out_vld_q || out_ready;
	assign in_ready = adv;

	// frame rotation
	logic ft_vld, ft_tag;
	tup_pkg::coord_t ft_u, ft_v;

	tup_turn u_frame_turn (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (in_valid),
		.in_tag  (1'b0),
		.in_u    (u_in),
		.in_v    (v_in),
		.turn    (fturn_q),
		.out_vld (ft_vld),
		.out_tag (ft_tag),
		.out_u   (ft_u),
		.out_v   (ft_v)
	);

	// subtract the frame translation
	tup_pkg::coord_t sh_u, sh_v, u_s3, v_s3;
	logic vld_s3, tag_s3;

	assign sh_u = shift_q[31:0];
	assign sh_v = shift_q[63:32];

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s3   <= tup_pkg::sat32(tup_pkg::wide_t'(ft_u) - tup_pkg::wide_t'(sh_u));
			v_s3   <= tup_pkg::sat32(tup_pkg::wide_t'(ft_v) - tup_pkg::wide_t'(sh_v));
			tag_s3 <= ft_tag;
		end
	end

	// frame test: the fraction must not pass coverage; without wrap the value must lie in 0..cov
	function automatic logic is_outside(input tup_pkg::coord_t x, input tup_pkg::coord_t cov,
		input logic wrap);
		logic o;
		o = tup_pkg::wide_t'(x[FB-1:0]) > tup_pkg::wide_t'(cov);
		if (!wrap && ((x < 0) || (x > cov)))
			o = 1'b1;
		return o;
	endfunction

	// wrap under unit coverage, then split into magnitudes for the divider
	function automatic tup_pkg::div_in_t div_prep(input tup_pkg::coord_t x,
		input tup_pkg::coord_t cov);
		tup_pkg::coord_t xw;
		logic [CW-1:0] ax, ad;
		tup_pkg::div_in_t d;
		xw = (cov < tup_pkg::FX_ONE) ? tup_pkg::coord_t'(x[FB-1:0]) : x;
		ax = xw[CW-1] ? (~xw + 1'b1) : xw;
		ad = cov[CW-1] ? (~cov + 1'b1) : cov;
		d.num  = {ax, {FB{1'b0}}};
		d.den  = ad;
		d.neg  = xw[CW-1] ^ cov[CW-1];
		d.zero = (cov == '0);
		d.ovf  = (ax >> (QW - FB)) >= ad;
		return d;
	endfunction

	tup_pkg::coord_t cu, cv;
	tup_pkg::div_in_t [1:0] dv_in;
	logic dv_tag_in;

	assign cu = cov_q[31:0];
	assign cv = cov_q[63:32];
	assign dv_in[0] = div_prep(u_s3, cu);
	assign dv_in[1] = div_prep(v_s3, cv);
	assign dv_tag_in = tag_s3 || is_outside(u_s3, cu, mode_q.wrap_u)
		|| is_outside(v_s3, cv, mode_q.wrap_v);

	logic dv_vld, dv_tag;
	tup_pkg::div_out_t [1:0] dv_out;

	tup_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s3),
		.in_tag  (dv_tag_in),
		.din     (dv_in),
		.out_vld (dv_vld),
		.out_tag (dv_tag),
		.dout    (dv_out)
	);

	// apply sign, saturate, and force zero for a zero divisor
	function automatic tup_pkg::coord_t q_sat(input tup_pkg::div_out_t d);
		if (d.zero)
			return '0;
		if (d.neg) begin
			if (d.ovf || (d.quo > tup_pkg::Q_NEG_LIM))
				return tup_pkg::SAT_MIN;
			return ~d.quo[CW-1:0] + 1'b1;
		end
		if (d.ovf || (d.quo > tup_pkg::Q_POS_LIM))
			return tup_pkg::SAT_MAX;
		return d.quo[CW-1:0];
	endfunction

	tup_pkg::coord_t u_s5, v_s5;
	logic vld_s5, tag_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s5   <= q_sat(dv_out[0]);
			v_s5   <= q_sat(dv_out[1]);
			tag_s5 <= dv_tag;
		end
	end

	// repeat, offset, stagger and mirror
	logic tl_vld, tl_tag;
	tup_pkg::coord_t tl_u, tl_v;

	tup_tile u_tile (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s5),
		.in_tag  (tag_s5),
		.in_u    (u_s5),
		.in_v    (v_s5),
		.rep     (rep_q),
		.off     (off_q),
		.mode    (mode_q),
		.out_vld (tl_vld),
		.out_tag (tl_tag),
		.out_u   (tl_u),
		.out_v   (tl_v)
	);

	// UV rotation
	logic uv_vld, uv_tag;
	tup_pkg::coord_t uv_u, uv_v;

	tup_turn u_uv_turn (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (tl_vld),
		.in_tag  (tl_tag),
		.in_u    (tl_u),
		.in_v    (tl_v),
		.turn    (uvturn_q),
		.out_vld (uv_vld),
		.out_tag (uv_tag),
		.out_u   (uv_u),
		.out_v   (uv_v)
	);

	// output register: outside the frame drop the coordinates to the floor value
	always_ff @(posedge clk) begin
		if (adv) begin
			u_out_q <= uv_tag ? tup_pkg::SAT_MIN : uv_u;
			v_out_q <= uv_tag ? tup_pkg::SAT_MIN : uv_v;
			frame_q <= !uv_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3    <= 1'b0;
			vld_s5    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s3    <= ft_vld;
			vld_s5    <= dv_vld;
			out_vld_q <= uv_vld;
		end
	end

	assign out_valid = out_vld_q;
	assign u_out     = u_out_q;
	assign v_out     = v_out_q;
	assign in_frame  = frame_q;

	a_outside_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_frame |-> (u_out == tup_pkg::SAT_MIN) && (v_out == tup_pkg::SAT_MIN))
		else $error("outside result without floor coordinates");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_vld_q |-> in_ready)
		else $error("input blocked while output register is empty");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(u_out) && $stable(v_out)
		&& $stable(in_frame))
		else $error("waiting result changed before its transfer");

endmodule
